/* sv/rswus_pkg.sv */
// Shared types and constants for the reservation station wakeup/select unit.
// No dependencies; every other file refers to this package by scoped names.
package rswus_pkg;

  localparam int RS_SLOTS     = 8;
  localparam int RS_TAG_COUNT = 32;

  // Field widths fixed by the interface.
  localparam int KIND_W = 5;
  localparam int FORM_W = 2;
  localparam int DATA_W = 32;
  localparam int TAG_W  = 5;
  localparam int TAG_SPAN = 1 << TAG_W;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_BROADCAST = 2'd1,
    CMD_CYCLE     = 2'd2,
    CMD_FLUSH     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FORM_REG_REG     = 2'd0,
    FORM_REG_IMM     = 2'd1,
    FORM_REG_REG_IMM = 2'd2,
    FORM_IMM_ONLY    = 2'd3
  } form_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ISSUED   = 3'd2,
    ST_NONE     = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    cmd_t              cmd;
    logic [KIND_W-1:0] kind;
    logic [FORM_W-1:0] form;
    logic              a_wait;
    logic [DATA_W-1:0] a_value;
    logic [TAG_W-1:0]  a_tag;
    logic              b_wait;
    logic [DATA_W-1:0] b_value;
    logic [TAG_W-1:0]  b_tag;
    logic [DATA_W-1:0] imm;
    logic [TAG_W-1:0]  dest;
  } rs_op_t;

endpackage

/* sv/rswus_front.sv */
// Front end: decodes one input word into a classified operation.
// Folds tags into the tag space and applies the operand form rules.
// Depends on rswus_pkg.
module rswus_front #(
  parameter int TAG_COUNT = rswus_pkg::RS_TAG_COUNT
) (
  input  logic [1:0]                    command,
  input  logic [rswus_pkg::KIND_W-1:0]  calc_kind,
  input  logic [rswus_pkg::FORM_W-1:0]  source_form,
  input  logic                          first_ready,
  input  logic [rswus_pkg::DATA_W-1:0]  first_value,
  input  logic [rswus_pkg::TAG_W-1:0]   first_tag,
  input  logic                          second_ready,
  input  logic [rswus_pkg::DATA_W-1:0]  second_value,
  input  logic [rswus_pkg::TAG_W-1:0]   second_tag,
  input  logic [rswus_pkg::DATA_W-1:0]  immediate,
  input  logic [rswus_pkg::TAG_W-1:0]   dest_tag,
  output rswus_pkg::rs_op_t             op
);

  logic [rswus_pkg::TAG_W-1:0] fold_tab [rswus_pkg::TAG_SPAN];
  rswus_pkg::cmd_t  cmd;
  rswus_pkg::form_t form;
  logic             use_a;
  logic             use_b;

  // constant fold table: tag modulo TAG_COUNT
  for (genvar g = 0; g < rswus_pkg::TAG_SPAN; g++) begin : g_fold
    assign fold_tab[g] = rswus_pkg::TAG_W'(g % TAG_COUNT);
  end

  assign cmd   = rswus_pkg::cmd_t'(command);
  assign form  = rswus_pkg::form_t'(source_form);
  assign use_a = (form != rswus_pkg::FORM_IMM_ONLY);
  assign use_b = (form == rswus_pkg::FORM_REG_REG) || (form == rswus_pkg::FORM_REG_REG_IMM);

  always_comb begin
    op.cmd     = cmd;
    op.kind    = calc_kind;
    op.form    = source_form;
    // unused sources read as ready with value zero
    op.a_wait  = use_a && !first_ready;
    op.a_value = (use_a && first_ready) ? first_value : '0;
    op.a_tag   = fold_tab[first_tag];
    op.b_wait  = use_b && !second_ready;
    op.b_value = (use_b && second_ready) ? second_value : '0;
    op.b_tag   = fold_tab[second_tag];
    // a broadcast carries its result value here, so zero only on a two-register insert
    op.imm     = (cmd == rswus_pkg::CMD_INSERT && form == rswus_pkg::FORM_REG_REG) ?
                 '0 : immediate;
    op.dest    = fold_tab[dest_tag];
  end

endmodule

/* sv/rswus_queue.sv */
// Two-word queue between front and back end.
// Depends on rswus_pkg for the word type.
module rswus_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_stall,
  input  rswus_pkg::rs_op_t push_op,
  output logic              pop_valid,
  input  logic              pop_take,
  output rswus_pkg::rs_op_t pop_op
);

  rswus_pkg::rs_op_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign push_stall = (count == 2'd2);
  assign push       = push_valid && !push_stall;
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop_take) rd_ptr <= !rd_ptr;
      case ({push, pop_take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_op;
  end

endmodule

/* sv/rswus_back.sv */
// Back end: slot storage, tag wakeup, lowest-index select, result register.
// Depends on rswus_pkg.
module rswus_back #(
  parameter int SLOTS = rswus_pkg::RS_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rswus_pkg::rs_op_t             op,
  input  logic                          op_valid,
  output logic                          op_take,
  output logic                          result_valid,
  input  logic                          result_stall,
  output rswus_pkg::status_t            status,
  output logic [rswus_pkg::KIND_W-1:0]  issued_kind,
  output logic [rswus_pkg::FORM_W-1:0]  issued_form,
  output logic [rswus_pkg::DATA_W-1:0]  issued_first,
  output logic [rswus_pkg::DATA_W-1:0]  issued_second,
  output logic [rswus_pkg::DATA_W-1:0]  issued_immediate,
  output logic [rswus_pkg::TAG_W-1:0]   issued_tag,
  output logic                          has_free_slot
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [SLOTS-1:0]             busy;
  logic [SLOTS-1:0]             busy_next;
  logic [rswus_pkg::KIND_W-1:0] slot_kind  [SLOTS];
  logic [rswus_pkg::FORM_W-1:0] slot_form  [SLOTS];
  logic [rswus_pkg::DATA_W-1:0] slot_a_val [SLOTS];
  logic [rswus_pkg::DATA_W-1:0] slot_b_val [SLOTS];
  logic [rswus_pkg::DATA_W-1:0] slot_imm   [SLOTS];
  logic [rswus_pkg::TAG_W-1:0]  slot_a_tag [SLOTS];
  logic [rswus_pkg::TAG_W-1:0]  slot_b_tag [SLOTS];
  logic [rswus_pkg::TAG_W-1:0]  slot_dest  [SLOTS];
  logic [SLOTS-1:0]             slot_a_wait;
  logic [SLOTS-1:0]             slot_b_wait;
  logic [SLOTS-1:0]             ready_vec;
  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;
  logic                         ready_found;
  logic [IDX_W-1:0]             ready_idx;
  rswus_pkg::status_t           status_next;
  logic                         issue;

  assign op_take   = op_valid && (!result_valid || !result_stall);
  assign ready_vec = busy & ~slot_a_wait & ~slot_b_wait;

  // lowest free slot and lowest ready slot
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    ready_found = 1'b0;
    ready_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (ready_vec[i]) begin
        ready_found = 1'b1;
        ready_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    busy_next   = busy;
    status_next = rswus_pkg::ST_DONE;
    case (op.cmd)
      rswus_pkg::CMD_INSERT: begin
        if (free_found) begin
          busy_next[free_idx] = 1'b1;
          status_next = rswus_pkg::ST_INSERTED;
        end else begin
          status_next = rswus_pkg::ST_FULL;
        end
      end
      rswus_pkg::CMD_CYCLE: begin
        if (ready_found) begin
          busy_next[ready_idx] = 1'b0;
          status_next = rswus_pkg::ST_ISSUED;
        end else begin
          status_next = rswus_pkg::ST_NONE;
        end
      end
      rswus_pkg::CMD_FLUSH: begin
        busy_next = '0;
      end
      default: begin
        busy_next = busy;
      end
    endcase
  end

  assign issue = (op.cmd == rswus_pkg::CMD_CYCLE) && ready_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (op_take) begin
        busy         <= busy_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // slot payload and result register
  always_ff @(posedge clk) begin
    if (op_take) begin
      if (op.cmd == rswus_pkg::CMD_INSERT && free_found) begin
        slot_kind[free_idx]   <= op.kind;
        slot_form[free_idx]   <= op.form;
        slot_a_val[free_idx]  <= op.a_value;
        slot_a_tag[free_idx]  <= op.a_tag;
        slot_a_wait[free_idx] <= op.a_wait;
        slot_b_val[free_idx]  <= op.b_value;
        slot_b_tag[free_idx]  <= op.b_tag;
        slot_b_wait[free_idx] <= op.b_wait;
        slot_imm[free_idx]    <= op.imm;
        slot_dest[free_idx]   <= op.dest;
      end
      if (op.cmd == rswus_pkg::CMD_BROADCAST) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (busy[i] && slot_a_wait[i] && slot_a_tag[i] == op.dest) begin
            slot_a_val[i]  <= op.imm;
            slot_a_wait[i] <= 1'b0;
          end
          if (busy[i] && slot_b_wait[i] && slot_b_tag[i] == op.dest) begin
            slot_b_val[i]  <= op.imm;
            slot_b_wait[i] <= 1'b0;
          end
        end
      end
      status           <= status_next;
      has_free_slot    <= |(~busy_next);
      issued_kind      <= issue ? slot_kind[ready_idx]  : '0;
      issued_form      <= issue ? slot_form[ready_idx]  : '0;
      issued_first     <= issue ? slot_a_val[ready_idx] : '0;
      issued_second    <= issue ? slot_b_val[ready_idx] : '0;
      issued_immediate <= issue ? slot_imm[ready_idx]   : '0;
      issued_tag       <= issue ? slot_dest[ready_idx]  : '0;
    end
  end

endmodule

/* sv/reservation_station_wakeup_select_unit.sv */
// Reservation station with tag wakeup and lowest-index select.
// A word accepted at the input is written into the queue, then into the back end's result register.
// Throughput: one word per cycle while the result channel does not stall; the back end retires one word each cycle it
// may write its result register, and a two-word queue absorbs output stalls.
// Reset (rst, synchronous): frees every slot, empties the queue, drops the result.
// Depends on rswus_pkg, rswus_front, rswus_queue, rswus_back.
module reservation_station_wakeup_select_unit #(
  parameter int SLOTS     = rswus_pkg::RS_SLOTS,
  parameter int TAG_COUNT = rswus_pkg::RS_TAG_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    command,
  input  logic [rswus_pkg::KIND_W-1:0]  calc_kind,
  input  logic [rswus_pkg::FORM_W-1:0]  source_form,
  input  logic                          first_ready,
  input  logic [rswus_pkg::DATA_W-1:0]  first_value,
  input  logic [rswus_pkg::TAG_W-1:0]   first_tag,
  input  logic                          second_ready,
  input  logic [rswus_pkg::DATA_W-1:0]  second_value,
  input  logic [rswus_pkg::TAG_W-1:0]   second_tag,
  input  logic [rswus_pkg::DATA_W-1:0]  immediate,
  input  logic [rswus_pkg::TAG_W-1:0]   dest_tag,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [2:0]                    status,
  output logic [rswus_pkg::KIND_W-1:0]  issued_kind,
  output logic [rswus_pkg::FORM_W-1:0]  issued_form,
  output logic [rswus_pkg::DATA_W-1:0]  issued_first,
  output logic [rswus_pkg::DATA_W-1:0]  issued_second,
  output logic [rswus_pkg::DATA_W-1:0]  issued_immediate,
  output logic [rswus_pkg::TAG_W-1:0]   issued_tag,
  output logic                          has_free_slot
);

  rswus_pkg::rs_op_t  front_op;
  rswus_pkg::rs_op_t  back_op;
  logic               back_valid;
  logic               back_take;
  rswus_pkg::status_t back_status;

  // Front: fold tags, zero unused operands, classify the command.
  rswus_front #(
    .TAG_COUNT (TAG_COUNT)
  ) u_front (
    .command      (command),
    .calc_kind    (calc_kind),
    .source_form  (source_form),
    .first_ready  (first_ready),
    .first_value  (first_value),
    .first_tag    (first_tag),
    .second_ready (second_ready),
    .second_value (second_value),
    .second_tag   (second_tag),
    .immediate    (immediate),
    .dest_tag     (dest_tag),
    .op           (front_op)
  );

  // Queue: hold classified words; stall the input only when both entries fill.
  rswus_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (item_valid),
    .push_stall (item_stall),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_take   (back_take),
    .pop_op     (back_op)
  );

  // Back: insert, wake up, select and issue, flush; register one result word.
  rswus_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .op               (back_op),
    .op_valid         (back_valid),
    .op_take          (back_take),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .status           (back_status),
    .issued_kind      (issued_kind),
    .issued_form      (issued_form),
    .issued_first     (issued_first),
    .issued_second    (issued_second),
    .issued_immediate (issued_immediate),
    .issued_tag       (issued_tag),
    .has_free_slot    (has_free_slot)
  );

  assign status = back_status;

endmodule

/* sv/rswus_checker.sv */
// Port-level checks for the reservation station unit, bound to the top level.
// Depends on rswus_pkg and reservation_station_wakeup_select_unit.
module rswus_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  status,
  input logic [4:0]  issued_kind,
  input logic [1:0]  issued_form,
  input logic [31:0] issued_first,
  input logic [31:0] issued_second,
  input logic [31:0] issued_immediate,
  input logic [4:0]  issued_tag,
  input logic        has_free_slot
);

  // a stalled result word stays valid with its status unchanged
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status))
    else $error("result word changed while stalled");

  a_zero_unless_issued: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != rswus_pkg::ST_ISSUED |->
      issued_kind == '0 && issued_form == '0 && issued_first == '0 &&
      issued_second == '0 && issued_immediate == '0 && issued_tag == '0)
    else $error("issue fields nonzero without an issue");

  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == rswus_pkg::ST_FULL |-> !has_free_slot)
    else $error("rejected insert reports a free slot");

  a_issue_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == rswus_pkg::ST_ISSUED |-> has_free_slot)
    else $error("issue left no free slot");

  a_reset_drop: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind reservation_station_wakeup_select_unit rswus_checker u_checker (.*);

/* sim/reservation_station_wakeup_select_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for reservation_station_wakeup_select_unit: a directed table
// and a random insert/wakeup/issue mix, checked word by word by a slot-level predictor.
// Depends on rswus_pkg and the reservation_station_wakeup_select_unit RTL.
module reservation_station_wakeup_select_unit_tb;

  localparam int RANDOM_WORDS = 1275;
  localparam int DRAIN_CYCLES = 10;      // covers the result register plus the two-word queue
  localparam int CYCLE_LIMIT  = 200000;

  // One input word as the sender builds it.
  typedef struct packed {
    rswus_pkg::cmd_t              cmd;
    logic [rswus_pkg::KIND_W-1:0] kind;
    logic [rswus_pkg::FORM_W-1:0] form;
    logic                         a_rdy;
    logic [rswus_pkg::DATA_W-1:0] a_val;
    logic [rswus_pkg::TAG_W-1:0]  a_tag;
    logic                         b_rdy;
    logic [rswus_pkg::DATA_W-1:0] b_val;
    logic [rswus_pkg::TAG_W-1:0]  b_tag;
    logic [rswus_pkg::DATA_W-1:0] imm;
    logic [rswus_pkg::TAG_W-1:0]  dest;
  } rs_word_t;

  // One result word: status, the dispatched entry, and the free-slot flag.
  typedef struct packed {
    rswus_pkg::status_t           st;
    logic [rswus_pkg::KIND_W-1:0] kind;
    logic [rswus_pkg::FORM_W-1:0] form;
    logic [rswus_pkg::DATA_W-1:0] first;
    logic [rswus_pkg::DATA_W-1:0] second;
    logic [rswus_pkg::DATA_W-1:0] imm;
    logic [rswus_pkg::TAG_W-1:0]  tag;
    logic                         free;
  } rs_result_t;

  // Directed row: a word plus, where it is obvious, the result typed in by hand.
  typedef struct {
    rs_word_t           w;
    bit                 fixed;
    rswus_pkg::status_t st;
    bit                 free;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         item_valid   = 1'b0;
  logic                         item_stall;
  logic [1:0]                   command      = '0;
  logic [rswus_pkg::KIND_W-1:0] calc_kind    = '0;
  logic [rswus_pkg::FORM_W-1:0] source_form  = '0;
  logic                         first_ready  = 1'b0;
  logic [rswus_pkg::DATA_W-1:0] first_value  = '0;
  logic [rswus_pkg::TAG_W-1:0]  first_tag    = '0;
  logic                         second_ready = 1'b0;
  logic [rswus_pkg::DATA_W-1:0] second_value = '0;
  logic [rswus_pkg::TAG_W-1:0]  second_tag   = '0;
  logic [rswus_pkg::DATA_W-1:0] immediate    = '0;
  logic [rswus_pkg::TAG_W-1:0]  dest_tag     = '0;

  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic [2:0]                   status;
  logic [rswus_pkg::KIND_W-1:0] issued_kind;
  logic [rswus_pkg::FORM_W-1:0] issued_form;
  logic [rswus_pkg::DATA_W-1:0] issued_first;
  logic [rswus_pkg::DATA_W-1:0] issued_second;
  logic [rswus_pkg::DATA_W-1:0] issued_immediate;
  logic [rswus_pkg::TAG_W-1:0]  issued_tag;
  logic                         has_free_slot;

  // Predicted station contents: one entry per slot, pend marks a source
  // still waiting for the producer whose tag sits beside it.
  bit                           rs_busy  [rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::KIND_W-1:0] rs_kind  [rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::FORM_W-1:0] rs_form  [rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::DATA_W-1:0] rs_a_val [rswus_pkg::RS_SLOTS];
  bit                           rs_a_pend[rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::TAG_W-1:0]  rs_a_tag [rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::DATA_W-1:0] rs_b_val [rswus_pkg::RS_SLOTS];
  bit                           rs_b_pend[rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::TAG_W-1:0]  rs_b_tag [rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::DATA_W-1:0] rs_imm   [rswus_pkg::RS_SLOTS];
  logic [rswus_pkg::TAG_W-1:0]  rs_dest  [rswus_pkg::RS_SLOTS];

  rs_result_t pending_results[$];
  dir_row_t   directed_rows[$];
  int         mismatches  = 0;
  int         words_sent  = 0;
  int         cycle_count = 0;
  bit         send_calm   = 1'b0;
  int         insert_pct  = 45;

  reservation_station_wakeup_select_unit dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .command          (command),
    .calc_kind        (calc_kind),
    .source_form      (source_form),
    .first_ready      (first_ready),
    .first_value      (first_value),
    .first_tag        (first_tag),
    .second_ready     (second_ready),
    .second_value     (second_value),
    .second_tag       (second_tag),
    .immediate        (immediate),
    .dest_tag         (dest_tag),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .status           (status),
    .issued_kind      (issued_kind),
    .issued_form      (issued_form),
    .issued_first     (issued_first),
    .issued_second    (issued_second),
    .issued_immediate (issued_immediate),
    .issued_tag       (issued_tag),
    .has_free_slot    (has_free_slot)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Reduce a tag into the station's tag space before storing or comparing it.
  function automatic logic [rswus_pkg::TAG_W-1:0] wrap_tag(logic [rswus_pkg::TAG_W-1:0] t);
    return rswus_pkg::TAG_W'(t % rswus_pkg::RS_TAG_COUNT);
  endfunction

  // Apply one accepted word to the predicted station and return its result word.
  function automatic rs_result_t station_step(rs_word_t w);
    rs_result_t res;
    int         slot;
    res    = '0;
    res.st = rswus_pkg::ST_DONE;
    slot   = -1;
    case (w.cmd)
      rswus_pkg::CMD_INSERT: begin
        // Take the lowest free slot; a full station rejects and changes nothing.
        for (int i = 0; i < rswus_pkg::RS_SLOTS; i++)
          if (!rs_busy[i] && slot < 0) slot = i;
        if (slot < 0) begin
          res.st = rswus_pkg::ST_FULL;
        end else begin
          rs_busy[slot] = 1'b1;
          rs_kind[slot] = w.kind;
          rs_form[slot] = w.form;
          rs_dest[slot] = wrap_tag(w.dest);
          rs_imm[slot]  = (w.form == rswus_pkg::FORM_REG_REG) ? '0 : w.imm;
          // Immediate-only leaves the first source unused: store it ready, zero.
          if (w.form == rswus_pkg::FORM_IMM_ONLY) begin
            rs_a_val[slot]  = '0;
            rs_a_pend[slot] = 1'b0;
            rs_a_tag[slot]  = '0;
          end else begin
            rs_a_val[slot]  = w.a_rdy ? w.a_val : '0;
            rs_a_pend[slot] = !w.a_rdy;
            rs_a_tag[slot]  = wrap_tag(w.a_tag);
          end
          // Only the two-register forms use the second source.
          if (w.form == rswus_pkg::FORM_REG_REG || w.form == rswus_pkg::FORM_REG_REG_IMM) begin
            rs_b_val[slot]  = w.b_rdy ? w.b_val : '0;
            rs_b_pend[slot] = !w.b_rdy;
            rs_b_tag[slot]  = wrap_tag(w.b_tag);
          end else begin
            rs_b_val[slot]  = '0;
            rs_b_pend[slot] = 1'b0;
            rs_b_tag[slot]  = '0;
          end
          res.st = rswus_pkg::ST_INSERTED;
        end
      end
      rswus_pkg::CMD_BROADCAST: begin
        // Wake every waiting source of a busy slot whose tag matches.
        for (int i = 0; i < rswus_pkg::RS_SLOTS; i++) begin
          if (rs_busy[i] && rs_a_pend[i] && rs_a_tag[i] == wrap_tag(w.dest)) begin
            rs_a_val[i]  = w.imm;
            rs_a_pend[i] = 1'b0;
          end
          if (rs_busy[i] && rs_b_pend[i] && rs_b_tag[i] == wrap_tag(w.dest)) begin
            rs_b_val[i]  = w.imm;
            rs_b_pend[i] = 1'b0;
          end
        end
      end
      rswus_pkg::CMD_CYCLE: begin
        // Issue the lowest busy slot with both sources ready, then free it.
        res.st = rswus_pkg::ST_NONE;
        for (int i = 0; i < rswus_pkg::RS_SLOTS; i++) begin
          if (res.st == rswus_pkg::ST_NONE && rs_busy[i] && !rs_a_pend[i] &&
              !rs_b_pend[i]) begin
            res.st     = rswus_pkg::ST_ISSUED;
            res.kind   = rs_kind[i];
            res.form   = rs_form[i];
            res.first  = rs_a_val[i];
            res.second = rs_b_val[i];
            res.imm    = rs_imm[i];
            res.tag    = rs_dest[i];
            rs_busy[i] = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < rswus_pkg::RS_SLOTS; i++) begin
          rs_busy[i]   = 1'b0;
          rs_kind[i]   = '0;
          rs_form[i]   = '0;
          rs_a_val[i]  = '0;
          rs_a_pend[i] = 1'b0;
          rs_a_tag[i]  = '0;
          rs_b_val[i]  = '0;
          rs_b_pend[i] = 1'b0;
          rs_b_tag[i]  = '0;
          rs_imm[i]    = '0;
          rs_dest[i]   = '0;
        end
      end
    endcase
    res.free = 1'b0;
    for (int i = 0; i < rswus_pkg::RS_SLOTS; i++)
      if (!rs_busy[i]) res.free = 1'b1;
    return res;
  endfunction

  function automatic rs_word_t mk(rswus_pkg::cmd_t c,
                                  logic [rswus_pkg::KIND_W-1:0] k,
                                  logic [rswus_pkg::FORM_W-1:0] f,
                                  logic ar, logic [rswus_pkg::DATA_W-1:0] av,
                                  logic [rswus_pkg::TAG_W-1:0] at,
                                  logic br, logic [rswus_pkg::DATA_W-1:0] bv,
                                  logic [rswus_pkg::TAG_W-1:0] bt,
                                  logic [rswus_pkg::DATA_W-1:0] imm,
                                  logic [rswus_pkg::TAG_W-1:0] d);
    rs_word_t w;
    w.cmd   = c;
    w.kind  = k;
    w.form  = f;
    w.a_rdy = ar;
    w.a_val = av;
    w.a_tag = at;
    w.b_rdy = br;
    w.b_val = bv;
    w.b_tag = bt;
    w.imm   = imm;
    w.dest  = d;
    return w;
  endfunction

  task automatic add_row(rs_word_t w, bit fixed, rswus_pkg::status_t st, bit free);
    dir_row_t r;
    r.w     = w;
    r.fixed = fixed;
    r.st    = st;
    r.free  = free;
    directed_rows.push_back(r);
  endtask

  // Source tags mostly come from a small pool so that broadcasts find waiters.
  function automatic logic [rswus_pkg::TAG_W-1:0] rand_tag();
    if ($urandom_range(0, 3) != 0) return rswus_pkg::TAG_W'($urandom_range(0, 3));
    return rswus_pkg::TAG_W'($urandom_range(0, rswus_pkg::TAG_SPAN - 1));
  endfunction

  // Prefer a tag that some busy slot is waiting on; otherwise any tag.
  function automatic logic [rswus_pkg::TAG_W-1:0] pick_wake_tag();
    logic [rswus_pkg::TAG_W-1:0] waiting_tags[$];
    for (int i = 0; i < rswus_pkg::RS_SLOTS; i++) begin
      if (rs_busy[i] && rs_a_pend[i]) waiting_tags.push_back(rs_a_tag[i]);
      if (rs_busy[i] && rs_b_pend[i]) waiting_tags.push_back(rs_b_tag[i]);
    end
    if (waiting_tags.size() == 0 || $urandom_range(0, 9) < 3)
      return rswus_pkg::TAG_W'($urandom_range(0, rswus_pkg::TAG_SPAN - 1));
    return waiting_tags[$urandom_range(0, waiting_tags.size() - 1)];
  endfunction

  // Random word: all fields random, command weighted by the current insert share,
  // broadcasts aimed mostly at live waiters, flushes rare.
  function automatic rs_word_t random_word(int ins_pct);
    rs_word_t w;
    int       r;
    w = mk(rswus_pkg::CMD_INSERT, rswus_pkg::KIND_W'($urandom_range(0, 31)),
           rswus_pkg::FORM_W'($urandom_range(0, 3)),
           1'($urandom_range(0, 1)), $urandom, rand_tag(),
           1'($urandom_range(0, 1)), $urandom, rand_tag(),
           $urandom, rswus_pkg::TAG_W'($urandom_range(0, rswus_pkg::TAG_SPAN - 1)));
    r = $urandom_range(0, 99);
    if (r < 2) begin
      w.cmd = rswus_pkg::CMD_FLUSH;
    end else if (r < 2 + ins_pct) begin
      w.cmd = rswus_pkg::CMD_INSERT;
    end else if (r < 2 + ins_pct + (98 - ins_pct) / 2) begin
      w.cmd  = rswus_pkg::CMD_BROADCAST;
      w.dest = pick_wake_tag();
    end else begin
      w.cmd = rswus_pkg::CMD_CYCLE;
    end
    return w;
  endfunction

  // Drive one word after a random gap, hold it until accepted, then predict.
  task automatic send_word(rs_word_t w, bit fixed, rswus_pkg::status_t fixed_st,
                           bit fixed_free);
    int         gap;
    rs_result_t want;
    if (words_sent % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command      <= w.cmd;
    calc_kind    <= w.kind;
    source_form  <= w.form;
    first_ready  <= w.a_rdy;
    first_value  <= w.a_val;
    first_tag    <= w.a_tag;
    second_ready <= w.b_rdy;
    second_value <= w.b_val;
    second_tag   <= w.b_tag;
    immediate    <= w.imm;
    dest_tag     <= w.dest;
    item_valid   <= 1'b1;
    // Hold the payload until an edge sees it with stall low.
    do @(posedge clk); while (item_stall !== 1'b0);
    want = station_step(w);
    if (fixed) begin
      want      = '0;
      want.st   = fixed_st;
      want.free = fixed_free;
    end
    pending_results.push_back(want);
    words_sent++;
  endtask

  function automatic void check_field(string name, logic [rswus_pkg::DATA_W-1:0] got,
                                      logic [rswus_pkg::DATA_W-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endfunction

  // Compare one accepted result word with the oldest prediction.
  task automatic check_result();
    rs_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result word with nothing pending: status %0d", status);
      return;
    end
    want = pending_results.pop_front();
    check_field("status", rswus_pkg::DATA_W'(status), rswus_pkg::DATA_W'(want.st));
    check_field("issued_kind", rswus_pkg::DATA_W'(issued_kind),
                rswus_pkg::DATA_W'(want.kind));
    check_field("issued_form", rswus_pkg::DATA_W'(issued_form),
                rswus_pkg::DATA_W'(want.form));
    check_field("issued_first", issued_first, want.first);
    check_field("issued_second", issued_second, want.second);
    check_field("issued_immediate", issued_immediate, want.imm);
    check_field("issued_tag", rswus_pkg::DATA_W'(issued_tag),
                rswus_pkg::DATA_W'(want.tag));
    check_field("has_free_slot", rswus_pkg::DATA_W'(has_free_slot),
                rswus_pkg::DATA_W'(want.free));
  endtask

  // Result side: stall for a randomly drawn hold before each word, with calm
  // stretches where it takes every word at once.
  initial begin : result_side
    int hold;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      check_result();
      taken++;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty station: nothing to issue, broadcast finds no waiter.
    add_row(mk(rswus_pkg::CMD_CYCLE, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0, 0, 0),
            1, rswus_pkg::ST_NONE, 1);
    add_row(mk(rswus_pkg::CMD_BROADCAST, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0,
               32'hFFFF_FFFF, 0), 1, rswus_pkg::ST_DONE, 1);
    // Fill all eight slots: every form, kind extremes, ready and waiting sources.
    // Two-register form drops its immediate; immediate-only drops both sources.
    add_row(mk(rswus_pkg::CMD_INSERT, 0, rswus_pkg::FORM_REG_REG, 1, 32'hFFFF_FFFF, 0,
               1, 32'h0, 0, 32'hFFFF_FFFF, 31), 1, rswus_pkg::ST_INSERTED, 1);
    add_row(mk(rswus_pkg::CMD_INSERT, 31, rswus_pkg::FORM_IMM_ONLY, 0, 32'h1234_5678, 31,
               0, 32'h9ABC_DEF0, 31, 32'hFFFF_FFFF, 0), 1, rswus_pkg::ST_INSERTED, 1);
    // Register plus immediate: the waiting second tag must be ignored.
    add_row(mk(rswus_pkg::CMD_INSERT, 13, rswus_pkg::FORM_REG_IMM, 0, 0, 5,
               0, 32'hFFFF_FFFF, 7, 32'h1234_5678, 3), 1, rswus_pkg::ST_INSERTED, 1);
    add_row(mk(rswus_pkg::CMD_INSERT, 14, rswus_pkg::FORM_REG_REG_IMM, 1, 32'hA5A5_A5A5, 9,
               0, 0, 5, 32'h8000_0000, 4), 1, rswus_pkg::ST_INSERTED, 1);
    add_row(mk(rswus_pkg::CMD_INSERT, 19, rswus_pkg::FORM_REG_REG_IMM, 0, 0, 31,
               0, 0, 31, 32'h0000_0001, 6), 1, rswus_pkg::ST_INSERTED, 1);
    add_row(mk(rswus_pkg::CMD_INSERT, 18, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0,
               32'hFFFF_FFFF, 7), 1, rswus_pkg::ST_INSERTED, 1);
    add_row(mk(rswus_pkg::CMD_INSERT, 1, rswus_pkg::FORM_REG_IMM, 1, 32'h8000_0000, 2,
               1, 32'h7FFF_FFFF, 2, 32'h7FFF_FFFF, 8), 1, rswus_pkg::ST_INSERTED, 1);
    add_row(mk(rswus_pkg::CMD_INSERT, 20, rswus_pkg::FORM_IMM_ONLY, 1, 32'hCAFE_F00D, 1,
               1, 32'h0BAD_BEEF, 1, 32'h0, 9), 1, rswus_pkg::ST_INSERTED, 0);
    // Station full: rejected, nothing changes.
    add_row(mk(rswus_pkg::CMD_INSERT, 5, rswus_pkg::FORM_REG_REG, 1, 1, 1, 1, 2, 2, 3, 10),
            1, rswus_pkg::ST_FULL, 0);
    // Drain the ready slots in index order, then find nothing ready.
    repeat (5) add_row(mk(rswus_pkg::CMD_CYCLE, 0, rswus_pkg::FORM_REG_REG,
                          0, 0, 0, 0, 0, 0, 0, 0), 0, rswus_pkg::ST_DONE, 0);
    // Unused source tag must not wake; shared tag wakes two slots at once.
    add_row(mk(rswus_pkg::CMD_BROADCAST, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0,
               32'h1111_1111, 7), 0, rswus_pkg::ST_DONE, 0);
    add_row(mk(rswus_pkg::CMD_BROADCAST, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0,
               32'hDEAD_BEEF, 5), 0, rswus_pkg::ST_DONE, 0);
    repeat (2) add_row(mk(rswus_pkg::CMD_CYCLE, 0, rswus_pkg::FORM_REG_REG,
                          0, 0, 0, 0, 0, 0, 0, 0), 0, rswus_pkg::ST_DONE, 0);
    // Both sources of one slot on the same tag, top and bottom of the tag range.
    add_row(mk(rswus_pkg::CMD_BROADCAST, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0,
               32'h5555_AAAA, 31), 0, rswus_pkg::ST_DONE, 0);
    add_row(mk(rswus_pkg::CMD_BROADCAST, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0,
               32'hFFFF_FFFF, 0), 0, rswus_pkg::ST_DONE, 0);
    add_row(mk(rswus_pkg::CMD_CYCLE, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0, 0, 0),
            0, rswus_pkg::ST_DONE, 0);
    // Flush with a live slot still held, then confirm the station is empty.
    add_row(mk(rswus_pkg::CMD_FLUSH, 31, rswus_pkg::FORM_IMM_ONLY, 1, 32'hFFFF_FFFF, 31,
               1, 32'hFFFF_FFFF, 31, 32'hFFFF_FFFF, 31), 1, rswus_pkg::ST_DONE, 1);
    add_row(mk(rswus_pkg::CMD_CYCLE, 0, rswus_pkg::FORM_REG_REG, 0, 0, 0, 0, 0, 0, 0, 0),
            1, rswus_pkg::ST_NONE, 1);

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].fixed, directed_rows[i].st,
                directed_rows[i].free);

    // Random mix; shift the insert share every 50 words so the station
    // swings between full and nearly empty.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 70;
          1:       insert_pct = 45;
          default: insert_pct = 20;
        endcase
      end
      send_word(random_word(insert_pct), 0, rswus_pkg::ST_DONE, 0);
    end
    item_valid <= 1'b0;

    // Wait out every pending result, then DRAIN_CYCLES more for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
